// File: hdl/sus_pkg.sv
package sus_pkg;

    // Default number of entries the set can hold.
    localparam int CAPACITY_DEF = 64;

    // Field widths fixed by the stream format.
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 3;
    localparam int POS_W      = 7;
    localparam int OUT_DATA_W = 16;

    // Operation carried in the input word's tuser.
    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    // Outcome codes reported on the result word's tuser.
    typedef enum logic [STAT_W-1:0]
    {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Commands broadcast to every cell of the row.
    typedef struct packed
    {
        logic capture;
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

// File: hdl/sus_cell.sv
module sus_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                              clk,
    input  sus_pkg::cell_ctrl_t               ctrl,
    input  logic signed [sus_pkg::VAL_W-1:0]  value,
    input  logic [CNT_W-1:0]                  count,
    input  logic                              left_below,
    input  logic signed [sus_pkg::VAL_W-1:0]  left_entry,
    input  logic signed [sus_pkg::VAL_W-1:0]  right_entry,
    output logic signed [sus_pkg::VAL_W-1:0]  entry,
    output logic                              below,
    output logic                              eq
);

    logic signed [sus_pkg::VAL_W-1:0] entry_reg;
    logic signed [sus_pkg::VAL_W-1:0] entry_next;
    logic                             below_reg;
    logic                             eq_reg;
    logic                             occupied;

    // The cell holds a live entry only when it lies under the fill count.
    assign occupied = CNT_W'(INDEX) < count;

    // On insert the first cell not below the value takes the value and the
    // cells above it take their left neighbor. On delete every cell from the
    // matching one up takes its right neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !below_reg)
        begin
            if (left_below || INDEX == 0)
            begin
                entry_next = value;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.del && !below_reg)
        begin
            entry_next = right_entry;
        end
    end

    // Stored entry and the compare flags taken when a word arrives.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.capture)
        begin
            below_reg <= occupied && (entry_reg < value);
            eq_reg    <= occupied && (entry_reg == value);
        end
    end

    assign entry = entry_reg;
    assign below = below_reg;
    assign eq    = eq_reg;

endmodule

// File: hdl/sorted_unique_set_top.sv
// Channel  Dir  tdata                                  tuser
// s_       in   [31:0] value (signed)                  [0] cmd (0 insert, 1 delete)
// m_       out  [6:0] position, [13:7] count, pad 0    [2:0] status
//
// With CNT_W = $clog2(CAPACITY + 1), each word is handled in turn: the cells
// compare at the accepting edge, a binary search over the CNT_W bits of the
// position, driven by the compare flags, finds the position, and the apply
// state shifts the row and loads the result; no new word is taken until then.
// Reset clears the fill count and the handshake state; entries need none.
// A result waiting on m_tready holds the next word in the apply state.
module sorted_unique_set_top #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sus_pkg::VAL_W-1:0]       s_tdata,   // [31:0] value
    input  logic                            s_tuser,   // [0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sus_pkg::OUT_DATA_W-1:0]  m_tdata,   // [6:0] position, [13:7] count
    output logic [sus_pkg::STAT_W-1:0]      m_tuser    // [2:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int BIT_W = $clog2(CNT_W);
    localparam int PAD_W = sus_pkg::OUT_DATA_W - 2 * sus_pkg::POS_W;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } state_t;

    state_t                             state_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [CNT_W-1:0]                   pos_reg;
    logic [BIT_W-1:0]                   bit_reg;
    sus_pkg::op_t                       cmd_reg;
    logic signed [sus_pkg::VAL_W-1:0]   value_reg;
    logic                               m_tvalid_reg;
    logic [sus_pkg::OUT_DATA_W-1:0]     m_tdata_reg;
    logic [sus_pkg::STAT_W-1:0]         m_tuser_reg;

    logic signed [sus_pkg::VAL_W-1:0]   cell_value;
    logic signed [sus_pkg::VAL_W-1:0]   entries [CAPACITY];
    logic [CAPACITY-1:0]                below;
    logic [CAPACITY-1:0]                eq;
    sus_pkg::cell_ctrl_t                ctrl;

    logic                               accept;
    logic                               out_free;
    logic                               fire;
    logic [CNT_W-1:0]                   trial;
    logic [CNT_W-1:0]                   trial_m1;
    logic                               trial_ok;
    logic                               hit;
    logic                               full;
    sus_pkg::status_t                   status;

    // Handshake.
    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == S_APPLY) && out_free;

    // Binary search step: the compare flags form a run of ones from cell
    // zero, so the position is the length of that run.
    assign trial    = pos_reg | (CNT_W'(1) << bit_reg);
    assign trial_m1 = trial - CNT_W'(1);
    assign trial_ok = (trial <= CNT_W'(CAPACITY)) && below[trial_m1[IDX_W-1:0]];

    // Outcome of the operation once the position is known.
    assign hit  = (pos_reg < count_reg) && eq[pos_reg[IDX_W-1:0]];
    assign full = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        status     = sus_pkg::ST_NOT_FOUND;
        count_next = count_reg;
        if (cmd_reg == sus_pkg::OP_INSERT)
        begin
            if (hit)
            begin
                status = sus_pkg::ST_DUPLICATE;
            end
            else if (full)
            begin
                status = sus_pkg::ST_FULL;
            end
            else
            begin
                status     = sus_pkg::ST_INSERTED;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (hit)
        begin
            status     = sus_pkg::ST_DELETED;
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Commands to the row of cells.
    assign ctrl.capture = accept;
    assign ctrl.ins     = fire && (status == sus_pkg::ST_INSERTED);
    assign ctrl.del     = fire && (status == sus_pkg::ST_DELETED);
    assign cell_value   = (state_reg == S_IDLE) ? $signed(s_tdata) : value_reg;

    // Row of compare-and-shift cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                             left_below;
        logic signed [sus_pkg::VAL_W-1:0] left_entry;
        logic signed [sus_pkg::VAL_W-1:0] right_entry;

        if (i == 0)
        begin : g_first
            assign left_below = 1'b0;
            assign left_entry = entries[i];
        end
        else
        begin : g_inner
            assign left_below = below[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_lower
            assign right_entry = entries[i+1];
        end

        sus_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .value       (cell_value),
            .count       (count_reg),
            .left_below  (left_below),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .below       (below[i]),
            .eq          (eq[i])
        );
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            bit_reg      <= '0;
            cmd_reg      <= sus_pkg::OP_INSERT;
            value_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !fire)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= sus_pkg::op_t'(s_tuser);
                        value_reg <= $signed(s_tdata);
                        pos_reg   <= '0;
                        bit_reg   <= BIT_W'(CNT_W - 1);
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (trial_ok)
                    begin
                        pos_reg <= trial;
                    end
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - BIT_W'(1);
                    end
                end
                S_APPLY:
                begin
                    if (out_free)
                    begin
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status;
                        m_tdata_reg  <= {PAD_W'(0), sus_pkg::POS_W'(count_next),
                                         sus_pkg::POS_W'(pos_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A rejected insert only happens with every cell occupied.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status == sus_pkg::ST_FULL |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status with free cells");

    // The search never lands beyond the live entries.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> pos_reg <= count_reg)
        else $error("position beyond fill count");

    // An accepted word always starts a search.
    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SEARCH)
        else $error("accepted word did not start a search");

    // A delete or insert changes the count by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins || ctrl.del |=>
        (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count moved by more than one");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CAP       = sus_pkg::CAPACITY_DEF;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int LATENCY   = CNT_W + 2;
    localparam int STALL_MAX = 2000;

    // One result word as the block should report it.
    typedef struct
    {
        sus_pkg::status_t status;
        logic [6:0]       position;
        logic [6:0]       count;
    } set_result_t;

    // Shadow copy of the sorted set and the results still owed by the block.
    class set_scoreboard;
        logic signed [sus_pkg::VAL_W-1:0] members [CAP];
        int unsigned                      size;
        set_result_t                      owed_q [$];
        int unsigned                      errors;

        function new();
            size   = 0;
            errors = 0;
        endfunction

        // Number of members strictly below v, which is also where v belongs.
        function int unsigned rank(logic signed [sus_pkg::VAL_W-1:0] v);
            int unsigned i;
            i = 0;
            while (i < size && members[i] < v)
                i++;
            return i;
        endfunction

        // Apply one accepted word to the shadow set and queue its result.
        function void note_input(sus_pkg::op_t op, logic signed [sus_pkg::VAL_W-1:0] v);
            int unsigned pos;
            int unsigned k;
            bit          hit;
            set_result_t res;
            pos = rank(v);
            hit = (pos < size) && (members[pos] == v);
            if (op == sus_pkg::OP_INSERT)
            begin
                if (hit)
                    res.status = sus_pkg::ST_DUPLICATE;
                else if (size >= CAP)
                    res.status = sus_pkg::ST_FULL;
                else
                begin
                    for (k = size; k > pos; k--)
                        members[k] = members[k - 1];
                    members[pos] = v;
                    size++;
                    res.status = sus_pkg::ST_INSERTED;
                end
            end
            else
            begin
                if (hit)
                begin
                    for (k = pos; k + 1 < size; k++)
                        members[k] = members[k + 1];
                    size--;
                    res.status = sus_pkg::ST_DELETED;
                end
                else
                    res.status = sus_pkg::ST_NOT_FOUND;
            end
            res.position = pos[6:0];
            res.count    = size[6:0];
            owed_q.push_back(res);
        endfunction

        task report_mismatch(string field, int unsigned got, int unsigned want);
            $display("%0t: mismatch in %s: got %0d, want %0d", $time, field, got, want);
            errors++;
        endtask

        // Compare one result word with the oldest owed result.
        task check_result(logic [sus_pkg::OUT_DATA_W-1:0] data,
                          logic [sus_pkg::STAT_W-1:0] stat);
            set_result_t want;
            if (owed_q.size() == 0)
            begin
                report_mismatch("result with none owed", 32'(data), 0);
                return;
            end
            want = owed_q.pop_front();
            if (stat !== want.status)
                report_mismatch("status", 32'(stat), 32'(want.status));
            if (data[6:0] !== want.position)
                report_mismatch("position", 32'(data[6:0]), 32'(want.position));
            if (data[13:7] !== want.count)
                report_mismatch("count", 32'(data[13:7]), 32'(want.count));
            if (data[15:14] !== 2'b00)
                report_mismatch("pad bits", 32'(data[15:14]), 0);
        endtask

        // Any value currently in the set, to aim deletes and duplicates.
        function logic signed [sus_pkg::VAL_W-1:0] pick_member();
            return members[$urandom_range(0, size - 1)];
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [sus_pkg::VAL_W-1:0]       s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [sus_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic [sus_pkg::STAT_W-1:0]      m_tuser;

    set_scoreboard sb = new();
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;
    int unsigned   stall_cycles;

    sorted_unique_set_top #(
        .CAPACITY (CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check accepted words and stall at random.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: give up when no word moves on either side for too long.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_MAX)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one word, with a random gap first, and note it once accepted.
    task automatic send_word(sus_pkg::op_t op, logic signed [sus_pkg::VAL_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(op, v);
    endtask

    // One random word: mostly small or present values, some wide noise.
    task automatic send_random_word(int unsigned ins_pct);
        sus_pkg::op_t                     op;
        logic signed [sus_pkg::VAL_W-1:0] v;
        int unsigned                      sel;
        op  = ($urandom_range(0, 99) < ins_pct) ? sus_pkg::OP_INSERT : sus_pkg::OP_DELETE;
        sel = $urandom_range(0, 99);
        if (sel < 40 && sb.size > 0)
            v = sb.pick_member();
        else if (sel < 85)
        begin
            v = $urandom_range(0, 80);
            v = v - 40;
        end
        else
            v = $urandom;
        send_word(op, v);
    endtask

    // Segments that fill the set, drain it, or churn it at random.
    task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct, int unsigned n);
        int unsigned sent;
        int unsigned seg_len;
        int unsigned ins_pct;
        int unsigned i;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n)
        begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            seg_len = $urandom_range(40, 160);
            for (i = 0; i < seg_len && sent < n; i++)
            begin
                send_random_word(ins_pct);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 62;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty store, extremes, duplicates, absent values.
        send_word(sus_pkg::OP_DELETE, 32'sd0);
        send_word(sus_pkg::OP_INSERT, 32'sd0);
        send_word(sus_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_word(sus_pkg::OP_INSERT, 32'h8000_0000);
        send_word(sus_pkg::OP_INSERT, -32'sd1);
        send_word(sus_pkg::OP_INSERT, 32'sd0);
        send_word(sus_pkg::OP_INSERT, 32'h8000_0000);
        send_word(sus_pkg::OP_DELETE, 32'sd5);
        send_word(sus_pkg::OP_DELETE, 32'h7FFF_FFFF);
        send_word(sus_pkg::OP_DELETE, 32'h8000_0000);
        send_word(sus_pkg::OP_DELETE, 32'h8000_0000);
        send_word(sus_pkg::OP_INSERT, 32'h5555_5555);
        send_word(sus_pkg::OP_INSERT, 32'hAAAA_AAAA);
        send_word(sus_pkg::OP_DELETE, -32'sd1);
        send_word(sus_pkg::OP_DELETE, 32'sd0);
        send_word(sus_pkg::OP_DELETE, 32'h5555_5555);
        send_word(sus_pkg::OP_DELETE, 32'hAAAA_AAAA);
        send_word(sus_pkg::OP_DELETE, 32'h7FFF_FFFF);

        // Random part under three idling patterns.
        run_phase(21, 62, 450);
        run_phase(62, 21, 450);
        run_phase(0, 0, 450);
        s_tvalid <= 1'b0;

        // Drain, then allow time for any stray result.
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);

        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
